// ----- design/mmte_pkg.sv -----
`timescale 1ns / 1ps

package mmte_pkg;

   localparam int CHAR_W  = 8;
   localparam int MAX_OUT = 6;
   localparam int MODE_W  = 3;
   localparam int NUM_W   = 3;

   localparam logic [MODE_W-1:0] MODE_BASE64 = 3'd0;
   localparam logic [MODE_W-1:0] MODE_URL    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HEX    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HTML   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_PASS   = 3'd4;

   localparam logic [CHAR_W-1:0] CH_PAD     = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [CHAR_W-1:0] CH_AMP     = 8'h26;
   localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;
   localparam logic [CHAR_W-1:0] CH_SEMI    = 8'h3B;

   // All characters caused by one input byte, oldest in entry 0.
   typedef struct packed {
      logic [MAX_OUT-1:0][CHAR_W-1:0] chars;
      logic [NUM_W-1:0]               num;
   } mmte_job_type;

   typedef struct packed {
      logic         valid;
      mmte_job_type job;
   } mmte_head_type;

   function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
      logic [CHAR_W-1:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
      logic [CHAR_W-1:0] c;
      if (v < 4'd10) begin
         c = 8'h30 + {4'h0, v};
      end else begin
         c = 8'h37 + {4'h0, v};
      end
      return c;
   endfunction

   function automatic logic url_plain(input logic [7:0] b);
      logic p;
      p = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
          (b >= 8'h61 && b <= 8'h7A) || b == 8'h2D || b == 8'h5F ||
          b == 8'h2E || b == 8'h7E;
      return p;
   endfunction

   // Shift-and-add-three conversion of a byte to three BCD digits.
   function automatic logic [11:0] to_bcd(input logic [7:0] v);
      logic [19:0] s;
      s = {12'd0, v};
      for (int i = 0; i < 8; i++) begin
         if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
         if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
         if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
         s = s << 1;
      end
      return s[19:8];
   endfunction

endpackage

// ----- design/mmte_front.sv -----
`timescale 1ns / 1ps

module mmte_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           csr_wr_data,
   input  logic                 csr_wr_en,
   input  logic                 in_valid,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   input  logic                 q_full,
   output logic                 in_ready,
   output logic                 push,
   output mmte_pkg::mmte_job_type job
);
   import mmte_pkg::*;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [3:0]        residual_ff, residual_in;
   logic [1:0]        phase_ff, phase_in;
   logic [1:0]        phase_cur;
   logic [11:0]       bcd;
   logic              accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign push     = accept;
   assign bcd      = to_bcd(in_byte);
   // The unused phase code behaves as the start of a group.
   assign phase_cur = (phase_ff == 2'd3) ? 2'd0 : phase_ff;

   always_comb begin
      mode_in = csr_wr_en ? csr_wr_data : mode_ff;
   end

   always_comb begin
      job         = '0;
      residual_in = residual_ff;
      phase_in    = phase_ff;
      unique case (mode_ff)
         MODE_BASE64: begin
            unique case (phase_cur)
               2'd0: begin
                  job.chars[0] = b64_char(in_byte[7:2]);
                  job.num      = 3'd1;
                  residual_in  = {2'b00, in_byte[1:0]};
                  phase_in     = 2'd1;
                  if (in_last) begin
                     job.chars[1] = b64_char({in_byte[1:0], 4'h0});
                     job.chars[2] = CH_PAD;
                     job.chars[3] = CH_PAD;
                     job.num      = 3'd4;
                  end
               end
               2'd1: begin
                  job.chars[0] = b64_char({residual_ff[1:0], in_byte[7:4]});
                  job.num      = 3'd1;
                  residual_in  = in_byte[3:0];
                  phase_in     = 2'd2;
                  if (in_last) begin
                     job.chars[1] = b64_char({in_byte[3:0], 2'b00});
                     job.chars[2] = CH_PAD;
                     job.num      = 3'd3;
                  end
               end
               default: begin
                  job.chars[0] = b64_char({residual_ff, in_byte[7:6]});
                  job.chars[1] = b64_char(in_byte[5:0]);
                  job.num      = 3'd2;
                  residual_in  = 4'h0;
                  phase_in     = 2'd0;
               end
            endcase
         end
         MODE_URL: begin
            if (url_plain(in_byte)) begin
               job.chars[0] = in_byte;
               job.num      = 3'd1;
            end else begin
               job.chars[0] = CH_PERCENT;
               job.chars[1] = hex_char(in_byte[7:4]);
               job.chars[2] = hex_char(in_byte[3:0]);
               job.num      = 3'd3;
            end
         end
         MODE_HEX: begin
            job.chars[0] = hex_char(in_byte[7:4]);
            job.chars[1] = hex_char(in_byte[3:0]);
            job.num      = 3'd2;
         end
         MODE_HTML: begin
            job.chars[0] = CH_AMP;
            job.chars[1] = CH_HASH;
            if (in_byte >= 8'd100) begin
               job.chars[2] = {4'h3, bcd[11:8]};
               job.chars[3] = {4'h3, bcd[7:4]};
               job.chars[4] = {4'h3, bcd[3:0]};
               job.chars[5] = CH_SEMI;
               job.num      = 3'd6;
            end else if (in_byte >= 8'd10) begin
               job.chars[2] = {4'h3, bcd[7:4]};
               job.chars[3] = {4'h3, bcd[3:0]};
               job.chars[4] = CH_SEMI;
               job.num      = 3'd5;
            end else begin
               job.chars[2] = {4'h3, bcd[3:0]};
               job.chars[3] = CH_SEMI;
               job.num      = 3'd4;
            end
         end
         default: begin
            job.chars[0] = in_byte;
            job.num      = 3'd1;
         end
      endcase
      if (in_last) begin
         residual_in = 4'h0;
         phase_in    = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_PASS;
         residual_ff <= 4'h0;
         phase_ff    <= 2'd0;
      end else begin
         mode_ff <= mode_in;
         if (accept) begin
            residual_ff <= residual_in;
            phase_ff    <= phase_in;
         end
      end
   end

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3) else $error("base64 phase reached the unused code");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> residual_ff == 4'h0 && phase_ff == 2'd0)
      else $error("end of payload did not clear the base64 state");

endmodule

// ----- design/mmte_queue.sv -----
`timescale 1ns / 1ps

module mmte_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mmte_pkg::mmte_job_type push_job,
   input  logic                   pop,
   output logic                   full,
   output mmte_pkg::mmte_head_type head
);
   import mmte_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mmte_job_type    store_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid) else $error("queue read while empty");

endmodule

// ----- design/mmte_back.sv -----
`timescale 1ns / 1ps

module mmte_back (
   input  logic                    clock,
   input  logic                    reset,
   input  mmte_pkg::mmte_head_type head,
   output logic                    pop,
   output logic                    out_valid,
   output logic [7:0]              out_char,
   output logic                    out_last,
   input  logic                    out_ready
);
   import mmte_pkg::*;

   logic [NUM_W-1:0]  idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic              load;
   logic              at_end;

   // A new character enters the output register when it is empty or being drained.
   assign load   = head.valid && (!valid_ff || out_ready);
   assign at_end = (idx_ff == head.job.num - 1'b1);
   assign pop    = load && at_end;

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in  = head.job.chars[idx_ff];
         last_in  = at_end;
         idx_in   = at_end ? '0 : idx_ff + 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> idx_ff < head.job.num)
      else $error("character index ran past the queued job");

   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      !head.valid |-> idx_ff == '0)
      else $error("character index not at start while queue is empty");

endmodule

// ----- design/multi_mode_text_encoder.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Signals                        Content
// req       in         req_tvalid/tready/tdata/tlast  tdata[7:0] data_byte, tlast end_of_payload
// rsp       out        rsp_tvalid/tready/tdata/tlast  tdata[7:0] out_char, tlast run_last
// csr       in         csr_wr_en, csr_wr_data         encoding_mode, written when csr_wr_en
//
// Each input byte gives 1 to 6 characters, and the result channel carries one character
// per cycle while rsp_tready is held high. The front encodes a byte in the cycle it is
// accepted; the job is written into the queue, and its first character then passes
// through the output register onto rsp. The job queue lets the front keep accepting
// while rsp stalls, until it is full. Reset is synchronous and clears the base64 state,
// the queue and the output valid flag, and sets the mode to pass-through.

module multi_mode_text_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data
);
   import mmte_pkg::*;

   mmte_job_type  job;
   mmte_head_type head;
   logic          push;
   logic          pop;
   logic          q_full;

   mmte_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_data (csr_wr_data),
      .csr_wr_en   (csr_wr_en),
      .in_valid    (req_tvalid),
      .in_byte     (req_tdata),
      .in_last     (req_tlast),
      .q_full      (q_full),
      .in_ready    (req_tready),
      .push        (push),
      .job         (job)
   );

   mmte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (job),
      .pop      (pop),
      .full     (q_full),
      .head     (head)
   );

   mmte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_ready (rsp_tready)
   );

endmodule

// ----- tb/sv/tb_multi_mode_text_encoder.sv -----
`timescale 1ns / 1ps

module tb_multi_mode_text_encoder;
   import mmte_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_REPORTS   = 20;

   localparam logic [8*64-1:0] B64_SET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam logic [8*16-1:0] HEX_SET = "0123456789ABCDEF";

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } enc_char_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;    // [7:0] data_byte
   logic              req_tlast = 1'b0;  // end_of_payload
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;         // [7:0] out_char
   logic              rsp_tlast;         // run_last
   logic              csr_wr_en = 1'b0;
   logic [MODE_W-1:0] csr_wr_data = '0;

   // Predictor copy of the block's configuration and base64 state.
   logic [MODE_W-1:0] cur_mode = MODE_PASS;
   logic [3:0]        b64_resid = '0;
   logic [1:0]        b64_phase = '0;

   // Characters of the byte being predicted, oldest in entry 0.
   logic [7:0]        pred_chars [MAX_OUT];
   int                pred_count = 0;

   // Newest prediction at the front, oldest at the back.
   enc_char_type expected_chars[$];
   int        mismatches = 0;
   int        bytes_sent = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 30;
   int        recv_idle_pct = 30;
   int        hold_req = 0;
   int        hold_seen = 0;
   int        hold_left = 0;

   multi_mode_text_encoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters outstanding", cycle_count,
                  expected_chars.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic logic [7:0] b64_sym(input logic [5:0] v);
      return B64_SET[8*(63-v) +: 8];
   endfunction

   function automatic logic [7:0] hex_sym(input logic [3:0] v);
      return HEX_SET[8*(15-v) +: 8];
   endfunction

   function automatic logic is_unreserved(input logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             b == "-" || b == "_" || b == "." || b == "~";
   endfunction

   task automatic put_pred(input logic [7:0] c);
      if (pred_count < MAX_OUT) begin
         pred_chars[pred_count] = c;
         pred_count++;
      end
   endtask

   // Works out the characters one accepted byte produces and queues them.
   task automatic predict_chars(input logic [7:0] b, input logic fin);
      logic [1:0]   ph;
      enc_char_type item;
      pred_count = 0;
      ph = (b64_phase == 2'd3) ? 2'd0 : b64_phase;
      case (cur_mode)
         MODE_BASE64: begin
            case (ph)
               2'd0: begin
                  put_pred(b64_sym(b[7:2]));
                  b64_resid = {2'b00, b[1:0]};
                  ph = 2'd1;
               end
               2'd1: begin
                  put_pred(b64_sym({b64_resid[1:0], b[7:4]}));
                  b64_resid = b[3:0];
                  ph = 2'd2;
               end
               default: begin
                  put_pred(b64_sym({b64_resid, b[7:6]}));
                  put_pred(b64_sym(b[5:0]));
                  b64_resid = '0;
                  ph = 2'd0;
               end
            endcase
            b64_phase = ph;
            if (fin && ph == 2'd1) begin
               put_pred(b64_sym({b64_resid[1:0], 4'b0000}));
               put_pred(CH_PAD);
               put_pred(CH_PAD);
            end else if (fin && ph == 2'd2) begin
               put_pred(b64_sym({b64_resid, 2'b00}));
               put_pred(CH_PAD);
            end
         end
         MODE_URL: begin
            if (is_unreserved(b)) begin
               put_pred(b);
            end else begin
               put_pred(CH_PERCENT);
               put_pred(hex_sym(b[7:4]));
               put_pred(hex_sym(b[3:0]));
            end
         end
         MODE_HEX: begin
            put_pred(hex_sym(b[7:4]));
            put_pred(hex_sym(b[3:0]));
         end
         MODE_HTML: begin
            put_pred(CH_AMP);
            put_pred(CH_HASH);
            if (b >= 8'd100) put_pred("0" + b / 8'd100);
            if (b >= 8'd10) put_pred("0" + (b / 8'd10) % 8'd10);
            put_pred("0" + b % 8'd10);
            put_pred(CH_SEMI);
         end
         default: begin
            put_pred(b);
         end
      endcase
      if (fin) begin
         b64_resid = '0;
         b64_phase = '0;
      end
      for (int i = 0; i < pred_count; i++) begin
         item.ch   = pred_chars[i];
         item.last = (i == pred_count - 1);
         expected_chars.push_front(item);
      end
   endtask

   // Compares each character leaving the block with the oldest prediction.
   always @(posedge clock) begin
      enc_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character %h", rsp_tdata));
         end else begin
            want = expected_chars.pop_back();
            if (rsp_tdata !== want.ch)
               report_mismatch($sformatf("out_char %h, predicted %h", rsp_tdata, want.ch));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("run_last %b, predicted %b", rsp_tlast, want.last));
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever a test requests one.
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen  <= hold_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Leaves req_tvalid high on return, so back-to-back bytes keep it asserted.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_chars(b, fin);
      bytes_sent++;
   endtask

   task automatic drain_output();
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic [MODE_W-1:0] m);
      drain_output();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_mode = m;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 8'hFF : 8'h00;
         1: return 8'($urandom_range(8'h7E, 8'h20));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_payload(input int len, input logic closed);
      for (int i = 0; i < len; i++) send_byte(pick_byte(), closed && i == len - 1);
   endtask

   task automatic test_reset_mode();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_base64_tails();
      set_mode(MODE_BASE64);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
   endtask

   task automatic test_url();
      set_mode(MODE_URL);
      send_byte("~", 1'b0);
      send_byte("-", 1'b0);
      send_byte("z", 1'b0);
      send_byte(" ", 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_hex_and_html();
      set_mode(MODE_HEX);
      send_byte(8'h00, 1'b0);
      send_byte(8'hAF, 1'b1);
      set_mode(MODE_HTML);
      send_byte(8'd9, 1'b0);
      send_byte(8'd10, 1'b0);
      send_byte(8'd100, 1'b0);
      send_byte(8'd255, 1'b1);
   endtask

   task automatic test_undefined_modes();
      for (int m = MODE_PASS + 1; m < 8; m++) begin
         set_mode(m[MODE_W-1:0]);
         send_byte(8'hA5, 1'b0);
      end
   endtask

   // The base64 group position survives a mode change; an end mark in
   // another mode still clears it.
   task automatic test_mode_switch();
      set_mode(MODE_BASE64);
      send_byte(8'h3C, 1'b0);
      set_mode(MODE_HEX);
      send_byte(8'h5A, 1'b0);
      set_mode(MODE_BASE64);
      send_byte(8'hC3, 1'b0);
      set_mode(MODE_PASS);
      send_byte(8'h41, 1'b1);
      set_mode(MODE_BASE64);
      send_byte(8'h7E, 1'b1);
   endtask

   task automatic test_random_payloads();
      int                setting;
      int                n_payloads;
      logic [MODE_W-1:0] m;
      setting = 0;
      while (bytes_sent < 200) begin
         if (setting < 8) m = setting[MODE_W-1:0];
         else if ($urandom_range(1)) m = MODE_BASE64;
         else m = MODE_W'($urandom_range(7));
         set_mode(m);
         n_payloads = $urandom_range(4, 2);
         for (int p = 0; p < n_payloads; p++)
            send_payload(($urandom_range(4) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1),
                         p < n_payloads - 1 || $urandom_range(4) != 0);
         setting++;
      end
   endtask

   task automatic test_full_rate();
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      set_mode(MODE_HTML);
      send_payload(20, 1'b1);
      set_mode(MODE_BASE64);
      repeat (5) send_payload($urandom_range(5, 1), 1'b1);
      send_idle_pct = 30;
      recv_idle_pct <= 30;
   endtask

   // The receiver holds off long enough for the job queue to fill and stall
   // the input; afterwards the sender waits for every character to arrive.
   task automatic test_backpressure();
      set_mode(MODE_HTML);
      send_idle_pct = 0;
      hold_req <= hold_req + 1;
      send_payload(24, 1'b1);
      send_idle_pct = 30;
      drain_output();
      set_mode(MODE_BASE64);
      repeat (4) send_payload($urandom_range(4, 1), 1'b1);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_mode();
      test_base64_tails();
      test_url();
      test_hex_and_html();
      test_undefined_modes();
      test_mode_switch();
      test_random_payloads();
      test_full_rate();
      test_backpressure();
      drain_output();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
